// ===== hw/rtl/ft8enc_pkg.sv =====
// Package for the FT8 frame tone encoder: sizes, codes, state encoding,
// generator ROM, sync and Gray tables. No dependencies.
package ft8enc_pkg;

    localparam int MSG_BITS    = 77;
    localparam int CRC_W       = 14;
    localparam int INFO_BITS   = 91;
    localparam int PARITY_BITS = 83;
    localparam int CODE_BITS   = 174;
    localparam int CHUNKS      = 11;
    localparam int PAIRS       = 40;
    localparam int TONES       = 79;
    localparam logic [CRC_W-1:0] CRC_POLY = 14'h2757;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_PARITY = 4'b0010,
        ST_EMIT   = 4'b0100,
        ST_WAIT   = 4'b1000
    } state_t;

    typedef struct packed {
        logic       load_chunk;
        logic       restart;
        logic       finish_crc;
        logic       parity_step;
        logic [6:0] parity_row;
        logic       tone_load;
        logic [5:0] pair_index;
    } ctrl_cmd_t;

    function automatic logic [91:0] gen_row(input logic [6:0] row);
        logic [91:0] r;
        r = '0;
        unique case (row)
            7'd0:  r = 92'h8329ce11bf31eaf509f27fc;
            7'd1:  r = 92'h761c264e25c259335493132;
            7'd2:  r = 92'hdc265902fb277c6410a1bdc;
            7'd3:  r = 92'h1b3f417858cd2dd33ec7f62;
            7'd4:  r = 92'h09fda4fee04195fd034783a;
            7'd5:  r = 92'h077cccc11b8873ed5c3d48a;
            7'd6:  r = 92'h29b62afe3ca036f4fe1a9da;
            7'd7:  r = 92'h6054faf5f35d96d3b0c8c3e;
            7'd8:  r = 92'he20798e4310eed27884ae90;
            7'd9:  r = 92'h775c9c08e80e26ddae56318;
            7'd10: r = 92'hb0b811028c2bf997213487c;
            7'd11: r = 92'h18a0c9231fc60adf5c5ea32;
            7'd12: r = 92'h76471e8302a0721e01b12b8;
            7'd13: r = 92'hffbccb80ca8341fafb47b2e;
            7'd14: r = 92'h66a72a158f9325a2bf67170;
            7'd15: r = 92'hc4243689fe85b1c51363a18;
            7'd16: r = 92'h0dff739414d1a1b34b1c270;
            7'd17: r = 92'h15b48830636c8b99894972e;
            7'd18: r = 92'h29a89c0d3de81d665489b0e;
            7'd19: r = 92'h4f126f37fa51cbe61bd6b94;
            7'd20: r = 92'h99c47239d0d97d3c84e0940;
            7'd21: r = 92'h1919b75119765621bb4f1e8;
            7'd22: r = 92'h09db12d731faee0b86df6b8;
            7'd23: r = 92'h488fc33df43fbdeea4eafb4;
            7'd24: r = 92'h827423ee40b675f756eb5fe;
            7'd25: r = 92'habe197c484cb74757144a9a;
            7'd26: r = 92'h2b500e4bc0ec5a6d2bdbdd0;
            7'd27: r = 92'hc474aa53d70218761669360;
            7'd28: r = 92'h8eba1a13db3390bd6718cec;
            7'd29: r = 92'h753844673a27782cc42012e;
            7'd30: r = 92'h06ff83a145c37035a5c1268;
            7'd31: r = 92'h3b37417858cc2dd33ec3f62;
            7'd32: r = 92'h9a4a5a28ee17ca9c324842c;
            7'd33: r = 92'hbc29f465309c977e89610a4;
            7'd34: r = 92'h2663ae6ddf8b5ce2bb29488;
            7'd35: r = 92'h46f231efe457034c1814418;
            7'd36: r = 92'h3fb2ce85abe9b0c72e06fbe;
            7'd37: r = 92'hde87481f282c153971a0a2e;
            7'd38: r = 92'hfcd7ccf23c69fa99bba1412;
            7'd39: r = 92'hf0261447e9490ca8e474cec;
            7'd40: r = 92'h4410115818196f95cdd7012;
            7'd41: r = 92'h088fc31df4bfbde2a4eafb4;
            7'd42: r = 92'hb8fef1b6307729fb0a078c0;
            7'd43: r = 92'h5afea7acccb77bbc9d99a90;
            7'd44: r = 92'h49a7016ac653f65ecdc9076;
            7'd45: r = 92'h1944d085be4e7da8d6cc7d0;
            7'd46: r = 92'h251f62adc4032f0ee714002;
            7'd47: r = 92'h56471f8702a0721e00b12b8;
            7'd48: r = 92'h2b8e4923f2dd51e2d537fa0;
            7'd49: r = 92'h6b550a40a66f4755de95c26;
            7'd50: r = 92'ha18ad28d4e27fe92a4f6c84;
            7'd51: r = 92'h10c2e586388cb82a3d80758;
            7'd52: r = 92'hef34a41817ee02133db2eb0;
            7'd53: r = 92'h7e9c0c54325a9c15836e000;
            7'd54: r = 92'h3693e572d1fde4cdf079e86;
            7'd55: r = 92'hbfb2cec5abe1b0c72e07fbe;
            7'd56: r = 92'h7ee18230c583cccc57d4b08;
            7'd57: r = 92'ha066cb2fedafc9f52664126;
            7'd58: r = 92'hbb23725abc47cc5f4cc4cd2;
            7'd59: r = 92'hded9dba3bee40c59b5609b4;
            7'd60: r = 92'hd9a7016ac653e6decdc9036;
            7'd61: r = 92'h9ad46aed5f707f280ab5fc4;
            7'd62: r = 92'he5921c77822587316d7d3c2;
            7'd63: r = 92'h4f14da8242a8b86dca73352;
            7'd64: r = 92'h8b8b507ad467d4441df770e;
            7'd65: r = 92'h22831c9cf1169467ad04b68;
            7'd66: r = 92'h213b838fe2ae54c38ee7180;
            7'd67: r = 92'h5d926b6dd71f085181a4e12;
            7'd68: r = 92'h66ab79d4b29ee6e69509e56;
            7'd69: r = 92'h958148682d748a38dd68baa;
            7'd70: r = 92'hb8ce020cf069c32a723ab14;
            7'd71: r = 92'hf4331d6d461607e95752746;
            7'd72: r = 92'h6da23ba424b9596133cf9c8;
            7'd73: r = 92'ha636bcbc7b30c5fbeae67fe;
            7'd74: r = 92'h5cb0d86a07df654a9089a20;
            7'd75: r = 92'hf11f106848780fc9ecdd80a;
            7'd76: r = 92'h1fbb5364fb8d2c9d730d5ba;
            7'd77: r = 92'hfcb86bc70a50c9d02a5d034;
            7'd78: r = 92'ha534433029eac15f322e34c;
            7'd79: r = 92'hc989d9c7c3d3b8c55d75130;
            7'd80: r = 92'h7bb38b2f0186d46643ae962;
            7'd81: r = 92'h2644ebadeb44b9467d1f42c;
            7'd82: r = 92'h608cc857594bfbb55d69600;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] sync_tone(input logic [2:0] idx);
        logic [2:0] t;
        t = 3'd0;
        unique case (idx)
            3'd0: t = 3'd3;
            3'd1: t = 3'd1;
            3'd2: t = 3'd4;
            3'd3: t = 3'd0;
            3'd4: t = 3'd6;
            3'd5: t = 3'd5;
            3'd6: t = 3'd2;
            default: t = 3'd0;
        endcase
        return t;
    endfunction

    function automatic logic [2:0] gray_tone(input logic [2:0] trio);
        logic [2:0] t;
        t = 3'd0;
        unique case (trio)
            3'd0: t = 3'd0;
            3'd1: t = 3'd1;
            3'd2: t = 3'd3;
            3'd3: t = 3'd2;
            3'd4: t = 3'd5;
            3'd5: t = 3'd6;
            3'd6: t = 3'd4;
            3'd7: t = 3'd7;
            default: t = 3'd0;
        endcase
        return t;
    endfunction

endpackage

// ===== hw/rtl/ft8enc_datapath.sv =====
// Datapath of the FT8 encoder: codeword register, CRC, parity and tone mapping.
// Depends on ft8enc_pkg.
module ft8enc_datapath
(
    input  logic                   clk,
    input  ft8enc_pkg::ctrl_cmd_t  cmd,
    input  logic [6:0]             payload_chunk,
    input  logic [3:0]             chunk_pos,
    output logic [2:0]             tone_a,
    output logic [2:0]             tone_b,
    output logic                   b_valid
);

    logic [ft8enc_pkg::CODE_BITS-1:0] code_reg;
    logic [ft8enc_pkg::CODE_BITS-1:0] code_next;
    logic [ft8enc_pkg::CRC_W-1:0]     crc_reg;
    logic [ft8enc_pkg::CRC_W-1:0]     crc_next;
    logic [ft8enc_pkg::CRC_W-1:0]     crc_chunk;
    logic [ft8enc_pkg::CRC_W-1:0]     crc_tail;
    logic [ft8enc_pkg::INFO_BITS-1:0] info_vec;
    logic [91:0]                      row_bits;
    logic                             row_parity;
    logic [6:0]                       tone_idx_a;
    logic [6:0]                       tone_idx_b;

    // Bit i of the codeword is stored at code_reg[CODE_BITS-1-i].
    function automatic logic [ft8enc_pkg::CRC_W-1:0] crc_clk(
        input logic [ft8enc_pkg::CRC_W-1:0] c, input logic b);
        logic fb;
        fb = c[ft8enc_pkg::CRC_W-1] ^ b;
        return {c[ft8enc_pkg::CRC_W-2:0], 1'b0} ^ (fb ? ft8enc_pkg::CRC_POLY : '0);
    endfunction

    function automatic logic [2:0] tone_at(input logic [6:0] idx,
                                           input logic [ft8enc_pkg::CODE_BITS-1:0] cw);
        logic [6:0] k;
        logic [7:0] b;
        logic [2:0] trio;
        k = 7'd0;
        trio = 3'd0;
        if (idx < 7'd7) begin
            return ft8enc_pkg::sync_tone(idx[2:0]);
        end
        if (idx >= 7'd36 && idx < 7'd43) begin
            return ft8enc_pkg::sync_tone(3'(idx - 7'd36));
        end
        if (idx >= 7'd72) begin
            return ft8enc_pkg::sync_tone(3'(idx - 7'd72));
        end
        k = (idx < 7'd36) ? (idx - 7'd7) : (idx - 7'd14);
        b = 8'(k) * 8'd3;
        trio = {cw[8'(ft8enc_pkg::CODE_BITS - 1) - b],
                cw[8'(ft8enc_pkg::CODE_BITS - 2) - b],
                cw[8'(ft8enc_pkg::CODE_BITS - 3) - b]};
        return ft8enc_pkg::gray_tone(trio);
    endfunction

    always_comb
    begin
        crc_chunk = ft8enc_pkg::CRC_W'(0);
        crc_chunk = cmd.restart ? '0 : crc_reg;
        for (int i = 0; i < 7; i++)
        begin
            crc_chunk = crc_clk(crc_chunk, payload_chunk[6-i]);
        end
        crc_tail = crc_reg;
        for (int i = 0; i < 5; i++)
        begin
            crc_tail = crc_clk(crc_tail, 1'b0);
        end
    end

    assign info_vec   = code_reg[ft8enc_pkg::CODE_BITS-1 -: ft8enc_pkg::INFO_BITS];
    assign row_bits   = ft8enc_pkg::gen_row(cmd.parity_row);
    assign row_parity = ^(row_bits[91:1] & info_vec);

    always_comb
    begin
        code_next = code_reg;
        crc_next  = crc_reg;
        if (cmd.load_chunk)
        begin
            code_next[8'(ft8enc_pkg::CODE_BITS - 1) - 8'(chunk_pos) * 8'd7 -: 7] = payload_chunk;
            crc_next = crc_chunk;
        end
        if (cmd.finish_crc)
        begin
            code_next[ft8enc_pkg::CODE_BITS-1-ft8enc_pkg::MSG_BITS -: ft8enc_pkg::CRC_W] =
                crc_tail;
            crc_next = '0;
        end
        if (cmd.parity_step)
        begin
            code_next[8'(ft8enc_pkg::PARITY_BITS - 1) - 8'(cmd.parity_row)] = row_parity;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        crc_reg  <= crc_next;
    end

    assign tone_idx_a = 7'(cmd.pair_index) * 7'd2;
    assign tone_idx_b = tone_idx_a + 7'd1;

    always_ff @(posedge clk)
    begin
        if (cmd.tone_load)
        begin
            tone_a  <= tone_at(tone_idx_a, code_reg);
            b_valid <= (tone_idx_b < 7'(ft8enc_pkg::TONES));
            tone_b  <= (tone_idx_b < 7'(ft8enc_pkg::TONES)) ? tone_at(tone_idx_b, code_reg)
                                                             : 3'd0;
        end
    end

endmodule

// ===== hw/rtl/ft8enc_ctrl.sv =====
// Controller of the FT8 encoder: chunk counting, parity row sequencing and
// output pair handshake. Depends on ft8enc_pkg.
module ft8enc_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   frame_start,
    output logic                   in_stall,
    input  logic                   out_stall,
    output logic                   out_valid,
    output logic                   out_last,
    output logic [3:0]             chunk_pos,
    output ft8enc_pkg::ctrl_cmd_t  cmd
);

    ft8enc_pkg::state_t state_reg, state_next;
    logic [3:0] count_reg, count_next;
    logic [6:0] row_reg, row_next;
    logic [5:0] pair_reg, pair_next;
    logic       ov_reg, ov_next;
    logic       last_reg, last_next;
    logic       take;

    assign in_stall  = (state_reg != ft8enc_pkg::ST_IDLE);
    assign take      = in_valid && !in_stall;
    assign chunk_pos = (frame_start || count_reg >= 4'(ft8enc_pkg::CHUNKS)) ? 4'd0 : count_reg;
    assign out_valid = ov_reg;
    assign out_last  = last_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        row_next   = row_reg;
        pair_next  = pair_reg;
        ov_next    = ov_reg;
        last_next  = last_reg;
        cmd        = '0;
        cmd.parity_row = row_reg;
        cmd.pair_index = pair_reg;
        unique case (state_reg)
            ft8enc_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    cmd.load_chunk = 1'b1;
                    cmd.restart    = (chunk_pos == 4'd0);
                    if (chunk_pos == 4'(ft8enc_pkg::CHUNKS - 1))
                    begin
                        count_next = 4'd0;
                        row_next   = 7'd0;
                        state_next = ft8enc_pkg::ST_PARITY;
                    end
                    else
                    begin
                        count_next = chunk_pos + 4'd1;
                    end
                end
            end
            ft8enc_pkg::ST_PARITY:
            begin
                if (row_reg == 7'd0)
                begin
                    cmd.finish_crc = 1'b1;
                    row_next = 7'd1;
                end
                else
                begin
                    cmd.parity_step = 1'b1;
                    cmd.parity_row  = row_reg - 7'd1;
                    if (row_reg == 7'(ft8enc_pkg::PARITY_BITS))
                    begin
                        pair_next  = 6'd0;
                        state_next = ft8enc_pkg::ST_EMIT;
                    end
                    else
                    begin
                        row_next = row_reg + 7'd1;
                    end
                end
            end
            ft8enc_pkg::ST_EMIT:
            begin
                cmd.tone_load = 1'b1;
                ov_next    = 1'b1;
                last_next  = (pair_reg == 6'(ft8enc_pkg::PAIRS - 1));
                state_next = ft8enc_pkg::ST_WAIT;
            end
            ft8enc_pkg::ST_WAIT:
            begin
                if (!out_stall)
                begin
                    ov_next = 1'b0;
                    if (last_reg)
                    begin
                        state_next = ft8enc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        pair_next  = pair_reg + 6'd1;
                        cmd.pair_index = pair_reg + 6'd1;
                        cmd.tone_load  = 1'b1;
                        ov_next    = 1'b1;
                        last_next  = (pair_reg + 6'd1 == 6'(ft8enc_pkg::PAIRS - 1));
                    end
                end
            end
            default:
            begin
                state_next = ft8enc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ft8enc_pkg::ST_IDLE;
            count_reg <= 4'd0;
            row_reg   <= 7'd0;
            pair_reg  <= 6'd0;
            ov_reg    <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            row_reg   <= row_next;
            pair_reg  <= pair_next;
            ov_reg    <= ov_next;
            last_reg  <= last_next;
        end
    end

endmodule

// ===== hw/rtl/ft8_frame_tone_encoder.sv =====
// Top level of the FT8 frame tone encoder: controller plus datapath.
// Depends on ft8enc_pkg, ft8enc_ctrl and ft8enc_datapath.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+----------------------------------------
//   input    | in_valid / in_stall      | payload_chunk, frame_start
//   output   | out_valid / out_stall    | tone_first, tone_second, second_valid,
//            |                          | frame_end
//
// Chunks 0 to 9 are stored as they are taken. The eleventh chunk starts the
// CRC finish and the parity work, one generator row per cycle; then the first
// pair is loaded and 40 pairs leave one per cycle while out_stall is low. Input
// is stalled from the eleventh chunk until the last pair is transferred. Reset
// clears control.
module ft8_frame_tone_encoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [6:0] payload_chunk,
    input  logic       frame_start,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] tone_first,
    output logic [2:0] tone_second,
    output logic       second_valid,
    output logic       frame_end
);

    ft8enc_pkg::ctrl_cmd_t cmd;
    logic [3:0]            chunk_pos;

    ft8enc_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .frame_start (frame_start),
        .in_stall    (in_stall),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_last    (frame_end),
        .chunk_pos   (chunk_pos),
        .cmd         (cmd)
    );

    ft8enc_datapath u_datapath
    (
        .clk           (clk),
        .cmd           (cmd),
        .payload_chunk (payload_chunk),
        .chunk_pos     (chunk_pos),
        .tone_a        (tone_first),
        .tone_b        (tone_second),
        .b_valid       (second_valid)
    );

endmodule
